@@ rtl/core/sfdc_pkg.sv @@
// Package for the stepped fan duty controller.
// Holds the configuration types, register indexes, duty level tables and PWM constants.
// No dependencies; every file of the controller imports it.
package sfdc_pkg;

	// Widths of the configuration registers and the stream fields.
	localparam int TEMP_W   = 12;
	localparam int DEG_W    = 7;
	localparam int BAND_W   = 5;
	localparam int HOLD_W   = 8;
	localparam int PCT_W    = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int TDATA_W  = 16;

	// Number of equal bands that start at the minimum temperature.
	localparam int NUM_BANDS = 6;

	// Timer top at which the compare value saturates.
	localparam int PWM_TOP = 79;

	// Duty levels: off, six bands, full.
	localparam int LEVEL_W = 3;
	localparam int NUM_LEVELS = 8;
	localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_GAP  = 3'd6;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 3'd7;

	// Duty percentage of each level.
	localparam logic [PCT_W-1:0] LEVEL_PCT [NUM_LEVELS] = '{
		7'd0, 7'd20, 7'd30, 7'd50, 7'd70, 7'd80, 7'd90, 7'd100
	};

	// floor(pct * 55 / 100) for each level, the compare value before the offset.
	localparam logic [PCT_W-1:0] LEVEL_SCALED [NUM_LEVELS] = '{
		7'd0, 7'd11, 7'd16, 7'd27, 7'd38, 7'd44, 7'd49, 7'd55
	};

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_TEMP     = 3'd0,
		CFG_MAX_TEMP     = 3'd1,
		CFG_BAND_WIDTH   = 3'd2,
		CFG_HOLD_SAMPLES = 3'd3,
		CFG_MIN_DUTY     = 3'd4
	} cfg_idx_t;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [DEG_W-1:0]  min_temp;
		logic [DEG_W-1:0]  max_temp;
		logic [BAND_W-1:0] band_width;
		logic [HOLD_W-1:0] hold_samples;
		logic [PCT_W-1:0]  min_duty;
	} cfg_t;

endpackage

@@ rtl/core/sfdc_cfg_regs.sv @@
// Configuration register file of the stepped fan duty controller.
// Depends on sfdc_pkg for the register indexes and the cfg_t struct.
module sfdc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfdc_pkg::CFG_DATA_W-1:0] cfg_data,
	output sfdc_pkg::cfg_t                cfg
);
	import sfdc_pkg::*;

	cfg_t cfg_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_temp     <= 7'd27;
			cfg_q.max_temp     <= 7'd40;
			cfg_q.band_width   <= 5'd2;
			cfg_q.hold_samples <= 8'd10;
			cfg_q.min_duty     <= 7'd0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_TEMP:     cfg_q.min_temp     <= cfg_data[DEG_W-1:0];
				CFG_MAX_TEMP:     cfg_q.max_temp     <= cfg_data[DEG_W-1:0];
				CFG_BAND_WIDTH:   cfg_q.band_width   <= cfg_data[BAND_W-1:0];
				CFG_HOLD_SAMPLES: cfg_q.hold_samples <= cfg_data[HOLD_W-1:0];
				CFG_MIN_DUTY:     cfg_q.min_duty     <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/sfdc_level_map.sv @@
// Maps one temperature sample to its stepped duty level.
// Depends on sfdc_pkg for widths, level codes and the cfg_t struct.
module sfdc_level_map (
	input  logic signed [sfdc_pkg::TEMP_W-1:0] temp,
	input  sfdc_pkg::cfg_t                     cfg,
	output logic [sfdc_pkg::LEVEL_W-1:0]       level
);
	import sfdc_pkg::*;

	localparam int CMP_W = 14;

	logic signed [CMP_W-1:0] t_ext;
	logic signed [CMP_W-1:0] lo;
	logic signed [CMP_W-1:0] hi;
	logic signed [CMP_W-1:0] bw;
	logic signed [CMP_W-1:0] th [NUM_BANDS+1];

	// Thresholds in 1/16 degree units: whole degrees shifted up by four.
	always_comb begin
		t_ext = CMP_W'(temp);
		lo    = $signed({3'b000, cfg.min_temp, 4'b0000});
		hi    = $signed({3'b000, cfg.max_temp, 4'b0000});
		bw    = $signed({5'b00000, cfg.band_width, 4'b0000});
		for (int p = 0; p <= NUM_BANDS; p++) begin
			th[p] = lo + CMP_W'(bw * p);
		end
	end

	// Full at or above the maximum, off below the minimum, else the first
	// band that holds the sample; past the last band the duty stays at 90.
	always_comb begin
		level = LEVEL_GAP;
		for (int p = NUM_BANDS - 1; p >= 0; p--) begin
			if (t_ext >= th[p] && t_ext < th[p+1]) begin
				level = LEVEL_W'(p + 1);
			end
		end
		if (t_ext < lo) begin
			level = LEVEL_OFF;
		end
		if (t_ext >= hi) begin
			level = LEVEL_FULL;
		end
	end

endmodule

@@ rtl/core/stepped_fan_duty_controller_top.sv @@
// Stepped fan duty controller, top level.
// An accepted sample reaches the output as a result item through the input register
// and the result register.
// Throughput: one sample per cycle while the receiver takes the results; the duty state
// updates as a sample moves from the input register into the result register.
// Reset (arst_n low, asynchronous): duty off, hold counter zero, fans off,
// registers at their defaults, both stages empty.
module stepped_fan_duty_controller_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [sfdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfdc_pkg::CFG_DATA_W-1:0] cfg_data,
	// Sample stream.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [sfdc_pkg::TDATA_W-1:0]    s_axis_tdata,  // [11:0] temp_sample, [15:12] zero
	// Result stream.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [sfdc_pkg::TDATA_W-1:0]    m_axis_tdata   // [6:0] duty_percent,
	                                                      // [13:7] pwm_compare,
	                                                      // [14] fan_enable, [15] kick_start
);
	import sfdc_pkg::*;

	cfg_t cfg;

	logic                      valid_s1;
	logic signed [TEMP_W-1:0]  temp_s1;
	logic                      valid_s2;
	logic [PCT_W-1:0]          duty_s2;
	logic [PCT_W-1:0]          cmp_s2;
	logic                      on_s2;
	logic                      kick_s2;

	logic [LEVEL_W-1:0]        level_q;
	logic [HOLD_W-1:0]         hold_cnt_q;
	logic                      fans_on_q;

	logic                      advance;
	logic [LEVEL_W-1:0]        new_level;
	logic [LEVEL_W-1:0]        next_level;
	logic [HOLD_W-1:0]         next_cnt;
	logic [HOLD_W-1:0]         cmp_sum;
	logic [HOLD_W-1:0]         cmp_sat;
	logic                      next_on;

	sfdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfdc_level_map u_map (
		.temp  (temp_s1),
		.cfg   (cfg),
		.level (new_level)
	);

	// Handshake: the first stage moves on when the result register is empty or its item is taken.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			temp_s1 <= $signed(s_axis_tdata[TEMP_W-1:0]);
		end
	end

	// Hold logic: a rise takes effect at once, a drop only after the hold
	// counter runs out. Compare value is the scaled duty plus offset, saturated; zero when off.
	always_comb begin
		if (new_level < level_q) begin
			next_cnt   = hold_cnt_q - 1'b1;
			next_level = level_q;
		end else begin
			next_cnt   = cfg.hold_samples;
			next_level = new_level;
		end
		if (next_cnt == '0) begin
			next_cnt   = cfg.hold_samples;
			next_level = new_level;
		end
		cmp_sum = {1'b0, LEVEL_SCALED[next_level]} + {1'b0, cfg.min_duty};
		if (next_level == LEVEL_OFF) begin
			cmp_sat = '0;
		end else if (cmp_sum > HOLD_W'(PWM_TOP)) begin
			cmp_sat = HOLD_W'(PWM_TOP);
		end else begin
			cmp_sat = cmp_sum;
		end
		next_on = (cmp_sat != '0);
	end

	// Duty state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= LEVEL_OFF;
			hold_cnt_q <= '0;
			fans_on_q  <= 1'b0;
		end else if (advance) begin
			level_q    <= next_level;
			hold_cnt_q <= next_cnt;
			fans_on_q  <= next_on;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_s2 <= LEVEL_PCT[next_level];
			cmp_s2  <= cmp_sat[PCT_W-1:0];
			on_s2   <= next_on;
			kick_s2 <= next_on && !fans_on_q;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {kick_s2, on_s2, cmp_s2, duty_s2};

endmodule

@@ verif/stepped_fan_duty_controller_top_tb.sv @@
// Self-checking testbench for the stepped fan duty controller top level.
// Depends on sfdc_pkg and stepped_fan_duty_controller_top; predicts every result item
// from its own model of the duty steps, hold counter and fan flags.
module stepped_fan_duty_controller_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfdc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 6;
	localparam int TEMP_MIN = -2048;
	localparam int TEMP_MAX = 2047;
	localparam int STEP_PCT [NUM_BANDS] = '{20, 30, 50, 70, 80, 90};
	localparam int GAP_PCT = 90;
	localparam int FULL_PCT = 100;
	localparam int PWM_SCALE_NUM = 55;
	localparam int PWM_SCALE_DEN = 100;
	// Index past the last register; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

	// Temperature classes used to aim samples at one duty step.
	localparam int ZONE_BELOW = 0;
	localparam int ZONE_GAP = NUM_BANDS + 1;
	localparam int ZONE_FULL = NUM_BANDS + 2;

	// Result item as packed on m_axis_tdata, highest field first.
	typedef struct packed {
		logic             kick_start;
		logic             fan_enable;
		logic [PCT_W-1:0] pwm_compare;
		logic [PCT_W-1:0] duty_percent;
	} fan_result_t;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_LONG_STALL} rx_pattern_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata;  // [11:0] temp_sample, [15:12] zero
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [TDATA_W-1:0]    m_axis_tdata;  // [6:0] duty_percent, [13:7] pwm_compare,
	                                      // [14] fan_enable, [15] kick_start

	// Model of the controller: registers and duty state.
	cfg_t              ctl_regs;
	logic [PCT_W-1:0]  held_duty;
	logic [HOLD_W-1:0] drop_countdown;
	logic              fans_on;

	fan_result_t pending_results [$];
	int          error_count = 0;
	int          burst_left = 0;
	int          idle_cycles = 0;

	// Receiver stall pattern state.
	rx_pattern_t rx_pattern = RX_ALWAYS;
	int          rx_pattern_left = 0;
	int          rx_cycle = 0;
	int          rx_stall_left = 0;
	logic        rx_ready_next;

	stepped_fan_duty_controller_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #6 clk = ~clk;

	// Stepped duty for one temperature under the current thresholds.
	function automatic int stepped_duty(input logic signed [TEMP_W-1:0] temp);
		int t;
		int lo;
		int hi;
		int bw;
		t  = temp;
		lo = int'(ctl_regs.min_temp) * 16;
		hi = int'(ctl_regs.max_temp) * 16;
		bw = int'(ctl_regs.band_width) * 16;
		if (t >= hi) return FULL_PCT;
		if (t < lo) return 0;
		for (int p = 0; p < NUM_BANDS; p++) begin
			if (t >= lo + bw * p && t < lo + bw * (p + 1)) return STEP_PCT[p];
		end
		return GAP_PCT;
	endfunction

	// Advance the duty state by one sample and return the result it produces.
	function automatic fan_result_t predict_fan_response(input logic signed [TEMP_W-1:0] temp);
		int          target;
		int          cmp;
		fan_result_t r;
		target = stepped_duty(temp);
		if (target < held_duty) begin
			drop_countdown = drop_countdown - 1'b1;
		end else begin
			held_duty = target[PCT_W-1:0];
			drop_countdown = ctl_regs.hold_samples;
		end
		if (drop_countdown == '0) begin
			drop_countdown = ctl_regs.hold_samples;
			held_duty = target[PCT_W-1:0];
		end
		if (held_duty == '0) begin
			cmp = 0;
		end else begin
			cmp = int'(held_duty) * PWM_SCALE_NUM / PWM_SCALE_DEN + int'(ctl_regs.min_duty);
			if (cmp > PWM_TOP) cmp = PWM_TOP;
		end
		r.duty_percent = held_duty;
		r.pwm_compare  = cmp[PCT_W-1:0];
		r.fan_enable   = (cmp != 0);
		r.kick_start   = r.fan_enable && !fans_on;
		fans_on        = r.fan_enable;
		return r;
	endfunction

	// Pick a temperature inside one zone of the current thresholds, often at its edges.
	function automatic logic signed [TEMP_W-1:0] temp_in_zone(input int zone);
		int lo;
		int hi;
		int bw;
		int a;
		int b;
		int pick;
		lo = int'(ctl_regs.min_temp) * 16;
		hi = int'(ctl_regs.max_temp) * 16;
		bw = int'(ctl_regs.band_width) * 16;
		if (zone == ZONE_BELOW) begin
			a = TEMP_MIN;
			b = lo - 1;
		end else if (zone == ZONE_FULL) begin
			a = hi;
			b = TEMP_MAX;
		end else if (zone == ZONE_GAP) begin
			a = lo + bw * NUM_BANDS;
			b = hi - 1;
		end else begin
			a = lo + bw * (zone - 1);
			b = lo + bw * zone - 1;
			if (b > hi - 1) b = hi - 1;
		end
		if (a < TEMP_MIN) a = TEMP_MIN;
		if (b > TEMP_MAX) b = TEMP_MAX;
		if (a > b) return TEMP_W'($urandom);
		case ($urandom_range(0, 7))
			0: pick = a;
			1: pick = b;
			default: pick = a + int'($urandom_range(0, b - a));
		endcase
		return pick[TEMP_W-1:0];
	endfunction

	// Send one temperature item, honoring the burst and gap pattern of the sender.
	task automatic send_temp(input logic signed [TEMP_W-1:0] temp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(TDATA_W - TEMP_W){1'b0}}, temp};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(predict_fan_response(temp));
		burst_left--;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	// Wait until every predicted item has come out, then let the pipeline settle.
	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_MIN_TEMP:     ctl_regs.min_temp     = data[DEG_W-1:0];
			CFG_MAX_TEMP:     ctl_regs.max_temp     = data[DEG_W-1:0];
			CFG_BAND_WIDTH:   ctl_regs.band_width   = data[BAND_W-1:0];
			CFG_HOLD_SAMPLES: ctl_regs.hold_samples = data[HOLD_W-1:0];
			CFG_MIN_DUTY:     ctl_regs.min_duty     = data[PCT_W-1:0];
			default: ;
		endcase
	endtask

	// Write all five registers; the block is drained first.
	task automatic apply_settings(input logic [CFG_DATA_W-1:0] min_t, input logic [CFG_DATA_W-1:0] max_t,
	                              input logic [CFG_DATA_W-1:0] bw, input logic [CFG_DATA_W-1:0] hold,
	                              input logic [CFG_DATA_W-1:0] md);
		stop_sending();
		wait_drained();
		write_reg(CFG_MIN_TEMP, min_t);
		write_reg(CFG_MAX_TEMP, max_t);
		write_reg(CFG_BAND_WIDTH, bw);
		write_reg(CFG_HOLD_SAMPLES, hold);
		write_reg(CFG_MIN_DUTY, md);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Every threshold edge under the reset settings, then a full hold-off drop.
	task automatic test_reset_thresholds();
		send_temp(-12'sd2048);
		send_temp(12'sd431);
		send_temp(12'sd432);
		send_temp(12'sd464);
		send_temp(12'sd496);
		send_temp(12'sd528);
		send_temp(12'sd560);
		send_temp(12'sd592);
		send_temp(12'sd624);
		send_temp(12'sd639);
		send_temp(12'sd640);
		send_temp(12'sd2047);
		repeat (10) send_temp(12'sd0);
		send_temp(12'sd432);
	endtask

	// Maximum checked before minimum, zero band width, saturation, hold of zero.
	task automatic test_corner_settings();
		apply_settings(8'd50, 8'd30, 8'd2, 8'd1, 8'd127);
		send_temp(12'sd480);
		send_temp(12'sd479);
		apply_settings(8'd20, 8'd60, 8'd0, 8'd1, 8'd30);
		send_temp(12'sd320);
		send_temp(12'sd959);
		send_temp(12'sd960);
		send_temp(12'sd319);
		apply_settings(8'd0, 8'd127, 8'd31, 8'd0, 8'd0);
		send_temp(12'sd0);
		send_temp(12'sd2031);
		send_temp(12'sd100);
		// A write beyond the last register must leave everything alone.
		stop_sending();
		wait_drained();
		write_reg(CFG_NO_REG, 8'hFF);
		@(negedge clk);
		cfg_we <= 1'b0;
		send_temp(12'sd2032);
		send_temp(-12'sd1);
	endtask

	// One setting: runs of samples aimed at one step, with noise, and a drain halfway.
	task automatic run_phase(input logic [CFG_DATA_W-1:0] min_t, input logic [CFG_DATA_W-1:0] max_t,
	                         input logic [CFG_DATA_W-1:0] bw, input logic [CFG_DATA_W-1:0] hold,
	                         input logic [CFG_DATA_W-1:0] md, input int n_items);
		int sent;
		int zone;
		int run_len;
		int longest;
		sent = 0;
		apply_settings(min_t, max_t, bw, hold, md);
		longest = (ctl_regs.hold_samples == '0) ? 256 : int'(ctl_regs.hold_samples);
		while (sent < n_items) begin
			zone = $urandom_range(ZONE_BELOW, ZONE_FULL);
			run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, longest + 3)
			                                      : $urandom_range(1, 8);
			for (int i = 0; i < run_len && sent < n_items; i++) begin
				if ($urandom_range(0, 9) == 0) send_temp(TEMP_W'($urandom));
				else send_temp(temp_in_zone(zone));
				sent++;
				if (sent == n_items / 2) begin
					stop_sending();
					wait_drained();
				end
			end
		end
	endtask

	task automatic test_fixed_settings();
		run_phase(8'd27, 8'd40, 8'd2, 8'd10, 8'd0, 150);
		run_phase(8'd0, 8'd127, 8'd21, 8'd1, 8'd0, 150);
		run_phase(8'd127, 8'd0, 8'd31, 8'd3, 8'd79, 100);
		run_phase(8'd20, 8'd60, 8'd0, 8'd5, 8'd127, 120);
		run_phase(8'd10, 8'd70, 8'd10, 8'd255, 8'd20, 400);
		run_phase(8'd0, 8'd60, 8'd10, 8'd0, 8'd5, 350);
	endtask

	// Random settings; unused upper data bits carry random values.
	task automatic test_random_settings();
		int min_t;
		int max_t;
		int bw;
		repeat (3) begin
			min_t = $urandom_range(0, 127);
			max_t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
			                                    : min_t + $urandom_range(0, 127 - min_t);
			bw = (max_t > min_t) ? (max_t - min_t) / NUM_BANDS : $urandom_range(0, 31);
			if (bw > 31) bw = 31;
			run_phase({1'($urandom), min_t[DEG_W-1:0]}, {1'($urandom), max_t[DEG_W-1:0]},
			          {3'($urandom), bw[BAND_W-1:0]}, 8'($urandom_range(0, 40)),
			          8'($urandom), 100);
		end
	endtask

	// Receiver: picks a new stall pattern at random whenever the current one runs out.
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_pattern_left == 0) begin
			rx_pattern = rx_pattern_t'($urandom_range(0, 3));
			rx_pattern_left = $urandom_range(32, 256);
		end else begin
			rx_pattern_left--;
		end
		case (rx_pattern)
			RX_ALWAYS:   rx_ready_next = 1'b1;
			RX_COIN:     rx_ready_next = 1'($urandom);
			RX_PERIODIC: rx_ready_next = (rx_cycle % 4) != 3;
			default: begin
				if (rx_stall_left == 0 && $urandom_range(0, 9) == 0)
					rx_stall_left = $urandom_range(1, 12);
				rx_ready_next = (rx_stall_left == 0);
				if (rx_stall_left != 0) rx_stall_left--;
			end
		endcase
		m_axis_tready <= rx_ready_next;
	end

	// Compare each result item with the oldest prediction.
	always @(posedge clk) begin
		fan_result_t got;
		fan_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result item, actual %h", $time, m_axis_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.duty_percent !== want.duty_percent) begin
					$display("%0t: duty_percent expected %0d actual %0d",
					         $time, want.duty_percent, got.duty_percent);
					error_count++;
				end
				if (got.pwm_compare !== want.pwm_compare) begin
					$display("%0t: pwm_compare expected %0d actual %0d",
					         $time, want.pwm_compare, got.pwm_compare);
					error_count++;
				end
				if (got.fan_enable !== want.fan_enable) begin
					$display("%0t: fan_enable expected %0d actual %0d",
					         $time, want.fan_enable, got.fan_enable);
					error_count++;
				end
				if (got.kick_start !== want.kick_start) begin
					$display("%0t: kick_start expected %0d actual %0d",
					         $time, want.kick_start, got.kick_start);
					error_count++;
				end
			end
		end
	end

	// Watchdog: too many cycles without any accepted item or register write.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_MIN_TEMP;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		// Reset state of the model.
		ctl_regs.min_temp     = 7'd27;
		ctl_regs.max_temp     = 7'd40;
		ctl_regs.band_width   = 5'd2;
		ctl_regs.hold_samples = 8'd10;
		ctl_regs.min_duty     = 7'd0;
		held_duty      = '0;
		drop_countdown = '0;
		fans_on        = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_thresholds();
		test_corner_settings();
		test_fixed_settings();
		test_random_settings();

		stop_sending();
		wait_drained();
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/sfdc_pkg.sv
rtl/core/sfdc_cfg_regs.sv
rtl/core/sfdc_level_map.sv
rtl/core/stepped_fan_duty_controller_top.sv
verif/stepped_fan_duty_controller_top_tb.sv
